// ===== src/image_orientation_transform_unit_defines.svh =====
// assertion macros shared by the rtl
`ifndef IMAGE_ORIENTATION_TRANSFORM_UNIT_DEFINES_SVH
`define IMAGE_ORIENTATION_TRANSFORM_UNIT_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define IOTU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("iotu property violated");
// condition that must never be seen out of reset
`define IOTU_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("iotu forbidden condition seen");
`else
`define IOTU_ASSERT(label, clk, rst, prop)
`define IOTU_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== src/iotu_pkg.sv =====
`default_nettype none

package iotu_pkg;

  localparam int DEF_MAX_LINES   = 256;
  localparam int DEF_MAX_SAMPLES = 256;
  localparam int DEF_PIXEL_BITS  = 64;

  // register file layout, word index
  typedef enum logic [1:0] {
    REG_SOURCE  = 2'd0,
    REG_TARGET  = 2'd1,
    REG_LINES   = 2'd2,
    REG_SAMPLES = 2'd3
  } reg_index_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } op_t;

  localparam logic [2:0] RESET_ORIENTATION = 3'd0;
  localparam logic [8:0] RESET_COUNT       = 9'd256;

  // transform code from source and target orientation
  function automatic logic [2:0] transform_code(input logic [2:0] src, input logic [2:0] tgt);
    logic [1:0] diff;
    diff = tgt[2] ? (src[1:0] - tgt[1:0]) : (tgt[1:0] - src[1:0]);
    return {src[2] ^ tgt[2], diff};
  endfunction

endpackage

`default_nettype wire

// ===== src/image_orientation_transform_unit.sv =====
// channel    | direction | signals                               | transaction
// -----------+-----------+---------------------------------------+------------------------------
// command    | in        | start, busy, operation, pixel_in      | start high and busy low
// result     | out       | done, pixel_out, end_of_line/_of_frame | done high, one cycle
// registers  | in/out    | psel, penable, pwrite, paddr, pwdata,  | psel, penable, pwrite, pready
//            |           | prdata, pready                        |
//
// one transaction per cycle, load or emit; busy stays low
// an emit's result, once it is taken, passes through the address stage register
//   and then through the frame memory's single port and read register
// a load is written from the address stage register in the cycle after it is taken, so an emit right behind it sees it
// synchronous active-high reset clears the positions and pipeline valids and sets the registers to their reset values
// the frame memory is not cleared; the receiver cannot stall results

`default_nettype none

`include "image_orientation_transform_unit_defines.svh"

module image_orientation_transform_unit
  import iotu_pkg::*;
#(
  parameter int MAX_LINES   = DEF_MAX_LINES,
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [63:0] pixel_in,
  // result channel
  output logic        done,
  output logic [63:0] pixel_out,
  output logic        end_of_line,
  output logic        end_of_frame,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // index widths for the input raster
  localparam int LW    = $clog2(MAX_LINES);
  localparam int SW    = $clog2(MAX_SAMPLES);
  localparam int LCW   = $clog2(MAX_LINES + 1);
  localparam int SCW   = $clog2(MAX_SAMPLES + 1);
  // output raster can be either way round
  localparam int MAXD  = (MAX_LINES > MAX_SAMPLES) ? MAX_LINES : MAX_SAMPLES;
  localparam int MW    = $clog2(MAXD);
  localparam int MCW   = $clog2(MAXD + 1);
  localparam int DEPTH = MAX_LINES * MAX_SAMPLES;
  localparam int AW    = $clog2(DEPTH);

  // configuration registers
  logic [2:0] source_orientation;
  logic [2:0] target_orientation;
  logic [8:0] image_lines;
  logic [8:0] image_samples;

  // raster positions
  logic [LW-1:0] load_line;
  logic [SW-1:0] load_sample;
  logic [MW-1:0] emit_line;
  logic [MW-1:0] emit_sample;

  // address stage
  logic                  st_valid;
  op_t                   st_op;
  logic [AW-1:0]         st_addr;
  logic [PIXEL_BITS-1:0] st_pixel;
  logic                  st_eol;
  logic                  st_eof;

  // memory stage
  logic [PIXEL_BITS-1:0] frame_store [DEPTH];
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  out_eol;
  logic                  out_eof;

  logic           accept;
  logic           cfg_write;
  reg_index_t     cfg_sel;
  logic [LCW-1:0] nl;
  logic [SCW-1:0] ns;
  logic [MCW-1:0] onl;
  logic [MCW-1:0] ons;
  logic [2:0]     xform;
  logic [LW-1:0]  nl1;
  logic [SW-1:0]  ns1;
  logic [LW-1:0]  i_l;
  logic [LW-1:0]  j_l;
  logic [SW-1:0]  i_s;
  logic [SW-1:0]  j_s;
  logic [LW-1:0]  src_line;
  logic [SW-1:0]  src_sample;
  logic           load_eol;
  logic           load_eof;
  logic           emit_eol;
  logic           emit_eof;
  logic [AW-1:0]  addr;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = reg_index_t'(paddr[3:2]);

  // register readback
  always_comb begin
    case (cfg_sel)
      REG_SOURCE:  prdata = 32'(source_orientation);
      REG_TARGET:  prdata = 32'(target_orientation);
      REG_LINES:   prdata = 32'(image_lines);
      REG_SAMPLES: prdata = 32'(image_samples);
      default:     prdata = '0;
    endcase
  end

  // clamp the counts: zero reads as one, overlarge saturates
  always_comb begin
    if (image_lines == '0) begin
      nl = LCW'(1);
    end else if (32'(image_lines) > 32'(MAX_LINES)) begin
      nl = LCW'(MAX_LINES);
    end else begin
      nl = LCW'(image_lines);
    end
    if (image_samples == '0) begin
      ns = SCW'(1);
    end else if (32'(image_samples) > 32'(MAX_SAMPLES)) begin
      ns = SCW'(MAX_SAMPLES);
    end else begin
      ns = SCW'(image_samples);
    end
  end

  // odd transforms swap lines and samples on output
  assign xform = transform_code(source_orientation, target_orientation);
  assign onl   = xform[0] ? MCW'(ns) : MCW'(nl);
  assign ons   = xform[0] ? MCW'(nl) : MCW'(ns);

  assign nl1 = LW'(nl - LCW'(1));
  assign ns1 = SW'(ns - SCW'(1));
  assign i_l = LW'(emit_line);
  assign j_l = LW'(emit_sample);
  assign i_s = SW'(emit_line);
  assign j_s = SW'(emit_sample);

  // output position to stored position
  always_comb begin
    case (xform)
      3'd0: begin
        src_line = i_l;        src_sample = j_s;
      end
      3'd1: begin
        src_line = j_l;        src_sample = ns1 - i_s;
      end
      3'd2: begin
        src_line = nl1 - i_l;  src_sample = ns1 - j_s;
      end
      3'd3: begin
        src_line = nl1 - j_l;  src_sample = i_s;
      end
      3'd4: begin
        src_line = nl1 - i_l;  src_sample = j_s;
      end
      3'd5: begin
        src_line = nl1 - j_l;  src_sample = ns1 - i_s;
      end
      3'd6: begin
        src_line = i_l;        src_sample = ns1 - j_s;
      end
      default: begin
        src_line = j_l;        src_sample = i_s;
      end
    endcase
  end

  // end of line and frame on both rasters
  assign load_eol = SCW'(load_sample) == ns - SCW'(1);
  assign load_eof = load_eol && (LCW'(load_line) == nl - LCW'(1));
  assign emit_eol = MCW'(emit_sample) == ons - MCW'(1);
  assign emit_eof = emit_eol && (MCW'(emit_line) == onl - MCW'(1));

  // row-major address, constant stride
  always_comb begin
    if (operation == OP_EMIT) begin
      addr = AW'(AW'(src_line) * AW'(MAX_SAMPLES) + AW'(src_sample));
    end else begin
      addr = AW'(AW'(load_line) * AW'(MAX_SAMPLES) + AW'(load_sample));
    end
  end

  // control: registers, positions and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      source_orientation <= RESET_ORIENTATION;
      target_orientation <= RESET_ORIENTATION;
      image_lines        <= RESET_COUNT;
      image_samples      <= RESET_COUNT;
      load_line          <= '0;
      load_sample        <= '0;
      emit_line          <= '0;
      emit_sample        <= '0;
      st_valid           <= 1'b0;
      done               <= 1'b0;
    end else begin
      st_valid <= accept;
      done     <= st_valid && (st_op == OP_EMIT);
      if (cfg_write) begin
        case (cfg_sel)
          REG_SOURCE:  source_orientation <= pwdata[2:0];
          REG_TARGET:  target_orientation <= pwdata[2:0];
          REG_LINES:   image_lines        <= pwdata[8:0];
          REG_SAMPLES: image_samples      <= pwdata[8:0];
          default:     ;
        endcase
        // any write restarts both rasters
        load_line   <= '0;
        load_sample <= '0;
        emit_line   <= '0;
        emit_sample <= '0;
      end else if (accept) begin
        if (operation == OP_LOAD) begin
          if (load_eol) begin
            load_sample <= '0;
            load_line   <= load_eof ? '0 : load_line + LW'(1);
          end else begin
            load_sample <= load_sample + SW'(1);
          end
        end else begin
          if (emit_eol) begin
            emit_sample <= '0;
            emit_line   <= emit_eof ? '0 : emit_line + MW'(1);
          end else begin
            emit_sample <= emit_sample + MW'(1);
          end
        end
      end
    end
  end

  // address stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      st_op    <= op_t'(operation);
      st_addr  <= addr;
      st_pixel <= pixel_in[PIXEL_BITS-1:0];
      st_eol   <= emit_eol;
      st_eof   <= emit_eof;
    end
  end

  // single-port frame memory, one access a cycle
  always_ff @(posedge clk) begin
    if (st_valid) begin
      if (st_op == OP_LOAD) begin
        frame_store[st_addr] <= st_pixel;
      end else begin
        rd_data <= frame_store[st_addr];
        out_eol <= st_eol;
        out_eof <= st_eof;
      end
    end
  end

  assign pixel_out    = 64'(rd_data);
  assign end_of_line  = out_eol;
  assign end_of_frame = out_eof;

  // a result only ever follows an emit in the address stage
  `IOTU_ASSERT(a_done_from_emit, clk, rst, done |-> $past(st_valid && st_op == OP_EMIT))
  // every emit taken gives a result once through the address and memory stages
  `IOTU_ASSERT(a_emit_gives_result, clk, rst, (accept && operation == OP_EMIT) |-> ##2 done)
  // frame end is always also a line end
  `IOTU_NEVER(a_eof_without_eol, clk, rst, done && end_of_frame && !end_of_line)
  // raster positions stay inside the configured image
  `IOTU_NEVER(a_load_in_range, clk, rst,
    (LCW'(load_line) >= nl) || (SCW'(load_sample) >= ns))
  `IOTU_NEVER(a_emit_in_range, clk, rst,
    (MCW'(emit_line) >= onl) || (MCW'(emit_sample) >= ons))

endmodule

`default_nettype wire

// ===== tb/reoriented_pixel_checker.sv =====
`default_nettype none

module reoriented_pixel_checker
  import iotu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        operation,
  input  logic [63:0] pixel_in,
  input  logic        done,
  input  logic [63:0] pixel_out,
  input  logic        end_of_line,
  input  logic        end_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS = DEF_MAX_LINES;
  localparam int unsigned COLS = DEF_MAX_SAMPLES;

  typedef enum logic [2:0] {
    XF_IDENTITY,
    XF_ROT90,
    XF_ROT180,
    XF_ROT270,
    XF_FLIP_LINES,
    XF_ANTI_TRANSPOSE,
    XF_FLIP_SAMPLES,
    XF_TRANSPOSE
  } reorient_t;

  typedef struct packed {
    logic [63:0] pixel;
    logic        eol;
    logic        eof;
  } out_pixel_t;

  out_pixel_t  awaited_pixels[$];
  logic [63:0] image_copy [ROWS*COLS];
  logic [2:0]  src_orient, tgt_orient;
  logic [8:0]  line_reg, sample_reg;
  int unsigned load_row, load_col, emit_row, emit_col;

  function automatic reorient_t reorient_code(input logic [2:0] src, input logic [2:0] tgt);
    logic [1:0] turn;
    if (src[2] == tgt[2]) begin
      turn = src[2] ? src[1:0] - tgt[1:0] : tgt[1:0] - src[1:0];
    end else begin
      turn = src[2] ? tgt[1:0] - src[1:0] : src[1:0] - tgt[1:0];
    end
    return reorient_t'({src[2] ^ tgt[2], turn});
  endfunction

  // zero counts as one, large counts saturate
  function automatic int unsigned effective_count(input logic [8:0] n, input int unsigned limit);
    if (n == 0) return 1;
    return (n > limit) ? limit : n;
  endfunction

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    int unsigned nl, ns, out_lines, out_samples, row, col;
    reorient_t   xf;
    out_pixel_t  want;
    logic [31:0] reg_value;
    if (rst) begin
      src_orient = RESET_ORIENTATION;
      tgt_orient = RESET_ORIENTATION;
      line_reg = RESET_COUNT;
      sample_reg = RESET_COUNT;
      load_row = 0;
      load_col = 0;
      emit_row = 0;
      emit_col = 0;
      awaited_pixels.delete();
    end else begin
      if (done) begin
        if (awaited_pixels.size() == 0) begin
          $display("%0t unexpected pixel %h eol %b eof %b", $time, pixel_out, end_of_line,
                   end_of_frame);
          fails++;
        end else begin
          want = awaited_pixels.pop_front();
          if (pixel_out !== want.pixel) begin
            $display("%0t pixel_out expected %h actual %h", $time, want.pixel, pixel_out);
            fails++;
          end
          if (end_of_line !== want.eol) begin
            $display("%0t end_of_line expected %b actual %b", $time, want.eol, end_of_line);
            fails++;
          end
          if (end_of_frame !== want.eof) begin
            $display("%0t end_of_frame expected %b actual %b", $time, want.eof, end_of_frame);
            fails++;
          end
        end
      end

      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_index_t'(paddr[3:2]))
            REG_SOURCE:  src_orient = pwdata[2:0];
            REG_TARGET:  tgt_orient = pwdata[2:0];
            REG_LINES:   line_reg = pwdata[8:0];
            REG_SAMPLES: sample_reg = pwdata[8:0];
            default: ;
          endcase
          // any write restarts both scans
          load_row = 0;
          load_col = 0;
          emit_row = 0;
          emit_col = 0;
        end else begin
          reg_value = '0;
          case (reg_index_t'(paddr[3:2]))
            REG_SOURCE:  reg_value[2:0] = src_orient;
            REG_TARGET:  reg_value[2:0] = tgt_orient;
            REG_LINES:   reg_value[8:0] = line_reg;
            REG_SAMPLES: reg_value[8:0] = sample_reg;
            default: ;
          endcase
          if (prdata !== reg_value) begin
            $display("%0t prdata at %h expected %h actual %h", $time, paddr, reg_value, prdata);
            fails++;
          end
        end
      end

      if (start && !busy) begin
        nl = effective_count(line_reg, ROWS);
        ns = effective_count(sample_reg, COLS);
        if (operation == OP_LOAD) begin
          image_copy[load_row * COLS + load_col] = pixel_in;
          if (load_col + 1 >= ns) begin
            load_col = 0;
            load_row = (load_row + 1 >= nl) ? 0 : load_row + 1;
          end else begin
            load_col++;
          end
        end else begin
          xf = reorient_code(src_orient, tgt_orient);
          out_lines = xf[0] ? ns : nl;
          out_samples = xf[0] ? nl : ns;
          case (xf)
            XF_IDENTITY: begin
              row = emit_row;
              col = emit_col;
            end
            XF_ROT90: begin
              row = emit_col;
              col = ns - 1 - emit_row;
            end
            XF_ROT180: begin
              row = nl - 1 - emit_row;
              col = ns - 1 - emit_col;
            end
            XF_ROT270: begin
              row = nl - 1 - emit_col;
              col = emit_row;
            end
            XF_FLIP_LINES: begin
              row = nl - 1 - emit_row;
              col = emit_col;
            end
            XF_ANTI_TRANSPOSE: begin
              row = nl - 1 - emit_col;
              col = ns - 1 - emit_row;
            end
            XF_FLIP_SAMPLES: begin
              row = emit_row;
              col = ns - 1 - emit_col;
            end
            default: begin
              row = emit_col;
              col = emit_row;
            end
          endcase
          want.pixel = image_copy[row * COLS + col];
          want.eol = (emit_col + 1 >= out_samples);
          want.eof = want.eol && (emit_row + 1 >= out_lines);
          awaited_pixels.push_back(want);
          if (want.eol) begin
            emit_col = 0;
            emit_row = want.eof ? 0 : emit_row + 1;
          end else begin
            emit_col++;
          end
        end
      end
    end
    pending = awaited_pixels.size();
  end

endmodule

`default_nettype wire

// ===== tb/image_orientation_transform_unit_test.sv =====
`default_nettype none

module image_orientation_transform_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iotu_pkg::*;

  // clock and the one reset at the start
  logic        clk = 1'b0;
  logic        rst = 1'b1;

  // command side, held at known values from time zero
  logic        start = 1'b0;
  logic        busy;
  logic        operation = 1'b0;
  logic [63:0] pixel_in = '0;

  // result side
  logic        done;
  logic [63:0] pixel_out;
  logic        end_of_line;
  logic        end_of_frame;

  // register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // verdict inputs from the checker
  int          fails;
  int          pending;

  // stimulus bookkeeping
  logic        idling = 1'b1;
  logic        in_random = 1'b0;
  int unsigned random_items = 0;
  int unsigned frame_size = 1;

  always #5 clk = ~clk;

  image_orientation_transform_unit dut (.*);

  reoriented_pixel_checker pixel_checker (.*);

  // generous ceiling, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[image_orientation_transform_unit] ERROR");
    $finish;
  end

  // same clamping the block applies, used to size the load of a frame and to cap random image sizes
  function automatic int unsigned clamped_count(input logic [8:0] n);
    if (n == 0) return 1;
    return (n > 256) ? 256 : n;
  endfunction

  // mostly tiny images, now and then a medium one or an out-of-range count
  function automatic logic [8:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 16) return 9'($urandom_range(1, 8));
    if (roll < 19) return 9'($urandom_range(9, 20));
    return $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(257, 511));
  endfunction

  // all-zero and all-one pixels turn up often enough to matter
  function automatic logic [63:0] any_pixel();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one command transaction; idle cycles carry junk on the payload
  task automatic issue(input op_t op, input logic [63:0] value);
    if (idling) begin
      while ($urandom_range(0, 99) < 38) begin
        start <= 1'b0;
        operation <= $urandom_range(0, 1);
        pixel_in <= {$urandom, $urandom};
        @(posedge clk);
      end
    end
    start <= 1'b1;
    operation <= op;
    pixel_in <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (in_random) random_items++;
  endtask

  // sender holds off until every emitted pixel has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // quiet point for register traffic: loads may still be landing in memory
  task automatic settle();
    drain();
    repeat (4) @(posedge clk);
  endtask

  // setup cycle, then access cycle until pready
  task automatic reg_access(input logic write, input reg_index_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // full register setting, read back straight after
  task automatic configure(input logic [2:0] src, tgt, input logic [8:0] lines, samples);
    settle();
    reg_access(1'b1, REG_SOURCE, src);
    reg_access(1'b1, REG_TARGET, tgt);
    reg_access(1'b1, REG_LINES, lines);
    reg_access(1'b1, REG_SAMPLES, samples);
    reg_access(1'b0, REG_SOURCE, '0);
    reg_access(1'b0, REG_TARGET, '0);
    reg_access(1'b0, REG_LINES, '0);
    reg_access(1'b0, REG_SAMPLES, '0);
    frame_size = clamped_count(lines) * clamped_count(samples);
  endtask

  // mostly emits, some loads into an already filled frame
  task automatic mix(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) drain();
      if ($urandom_range(0, 9) < 7) issue(OP_EMIT, any_pixel());
      else issue(OP_LOAD, any_pixel());
    end
  endtask

  initial begin
    logic [2:0]  src, tgt;
    logic [8:0]  lines, samples;
    int unsigned phase, mixes;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: a 2 x 3 image holding the pixel extremes, replayed three ways
    idling = 1'b0;
    configure(3'd0, 3'd0, 9'd2, 9'd3);
    issue(OP_LOAD, 64'h0000_0000_0000_0000);
    issue(OP_LOAD, 64'hffff_ffff_ffff_ffff);
    issue(OP_LOAD, 64'h8000_0000_0000_0000);
    issue(OP_LOAD, 64'h0000_0000_0000_0001);
    issue(OP_LOAD, 64'haaaa_aaaa_aaaa_aaaa);
    issue(OP_LOAD, 64'h5555_5555_5555_5555);
    repeat (6) issue(OP_EMIT, '0);
    // quarter turn: output becomes 3 x 2
    settle();
    reg_access(1'b1, REG_TARGET, 32'd1);
    repeat (6) issue(OP_EMIT, '0);
    // mirrored source, flips lines against samples
    settle();
    reg_access(1'b1, REG_SOURCE, 32'd4);
    repeat (6) issue(OP_EMIT, '0);

    // random phases: fill the frame, then mixed traffic under several orientations
    in_random = 1'b1;
    phase = 0;
    while (random_items < 400 || phase < 5) begin
      idling = 1'b1;
      src = $urandom_range(0, 7);
      tgt = $urandom_range(0, 7);
      case (phase)
        0: begin
          // line count beyond range saturates, zero samples reads as one
          lines = 9'd511;
          samples = 9'd0;
          src = 3'd7;
          tgt = 3'd7;
        end
        1: begin
          // zero lines reads as one
          lines = 9'd0;
          samples = 9'd12;
          src = 3'd0;
          tgt = 3'd7;
        end
        2: begin
          // single pixel image
          lines = 9'd1;
          samples = 9'd0;
        end
        3: begin
          // long stretch with no random idle cycles
          lines = 9'd2;
          samples = 9'd16;
          idling = 1'b0;
        end
        default: begin
          lines = pick_count();
          samples = pick_count();
          if (clamped_count(lines) * clamped_count(samples) > 64) begin
            lines = 9'd8;
            samples = 9'd8;
          end
        end
      endcase
      configure(src, tgt, lines, samples);

      // now and then an abandoned load, restarted by a register write
      if (frame_size > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, (frame_size > 16) ? 16 : frame_size - 1))
          issue(OP_LOAD, any_pixel());
        settle();
        reg_access(1'b1, REG_LINES, lines);
      end
      repeat (frame_size) issue(OP_LOAD, any_pixel());

      // same image, fresh orientations; every write restarts the scans
      repeat ($urandom_range(1, 3)) begin
        mixes = $urandom_range(frame_size / 2 + 1, 2 * frame_size + 4);
        if (mixes > 12) mixes = 12;
        mix(mixes);
        settle();
        reg_access(1'b1, REG_SOURCE, $urandom_range(0, 7));
        reg_access(1'b1, REG_TARGET, $urandom_range(0, 7));
      end
      mixes = $urandom_range(frame_size / 2 + 1, 2 * frame_size + 4);
      if (mixes > 12) mixes = 12;
      mix(mixes);
      phase++;
    end

    // let the last results drain, then wait for strays
    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("[image_orientation_transform_unit] OK");
    end else begin
      $display("[image_orientation_transform_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/iotu_pkg.sv
src/image_orientation_transform_unit.sv
tb/reoriented_pixel_checker.sv
tb/image_orientation_transform_unit_test.sv
